// ===== rtl/tcnn_pkg.sv =====
`timescale 1ns / 1ps

package tcnn_pkg;

  localparam int SIG_DEPTH_DEF = 256;

  localparam int PIX_W = 16;
  localparam int W_W = 16;
  localparam int SIG_W = 16;
  localparam int A_W = 35;
  localparam int S_W = 35;
  localparam int PROD_W = A_W + W_W;
  localparam int HID_W = 52;
  localparam int OACC_W = 35;
  localparam int OUT_W = 32;
  localparam int FRAC_DROP = 12;
  localparam int HLIM_SHIFT = 42;

  localparam int WEIGHT_COUNT = 20;
  localparam int WADDR_W = 5;
  localparam int PIX_COUNT = 9;
  localparam int PIX_SEL_W = 4;
  localparam int HID_COUNT = 3;
  localparam int HSEL_W = 2;

  localparam int W_POS_BASE = 12;
  localparam int W_OUT_BASE = 16;

  localparam int UC_LEN = 64;
  localparam int PC_W = 6;
  localparam int UC_SIG = 60;
  localparam int UC_FIN = 63;
  localparam logic [HSEL_W-1:0] LOOP_LAST = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam longint SIG_HALF_RANGE = 64'sd524288;
  localparam longint unsigned ONE_Q31 = 64'd1 << 31;

  typedef enum logic [1:0] {ACT_MAC, ACT_IDX, ACT_ROM, ACT_FIN} act_t;
  typedef enum logic [1:0] {A_PIX, A_SACC, A_SIG} asel_t;
  typedef enum logic [1:0] {D_SACC, D_HID, D_OUT} dst_t;
  typedef enum logic [1:0] {J_NEXT, J_LOOP, J_END} jmp_t;

  typedef struct packed {
    act_t                 act;
    asel_t                asel;
    dst_t                 dst;
    jmp_t                 jmp;
    logic                 clr;
    logic                 use_cnt;
    logic [PIX_SEL_W-1:0] pix;
    logic [WADDR_W-1:0]   waddr;
    logic [HSEL_W-1:0]    hsel;
    logic [PC_W-1:0]      target;
  } ucw_t;

  function automatic ucw_t mk_word(input act_t act, input asel_t asel, input dst_t dst,
                                   input jmp_t jmp, input logic clr, input logic use_cnt,
                                   input logic [PIX_SEL_W-1:0] pix,
                                   input logic [WADDR_W-1:0] waddr,
                                   input logic [HSEL_W-1:0] hsel,
                                   input logic [PC_W-1:0] target);
    ucw_t w;
    w.act = act;
    w.asel = asel;
    w.dst = dst;
    w.jmp = jmp;
    w.clr = clr;
    w.use_cnt = use_cnt;
    w.pix = pix;
    w.waddr = waddr;
    w.hsel = hsel;
    w.target = target;
    return w;
  endfunction

  // e^-t, t in Q16, result Q31; cubic series raised to the 256th power
  function automatic longint unsigned exp_neg_q31(input longint unsigned t);
    longint unsigned u;
    longint unsigned u2;
    longint unsigned u3;
    longint unsigned e;
    int k;
    u = t << 7;
    u2 = (u * u) >> 31;
    u3 = (u2 * u) >> 31;
    e = ONE_Q31 - u + (u2 >> 1) - u3 / 6;
    for (k = 0; k < 8; k++) begin
      e = (e * e) >> 31;
    end
    return e;
  endfunction

endpackage

// ===== rtl/tcnn_sig_rom.sv =====
`timescale 1ns / 1ps

module tcnn_sig_rom import tcnn_pkg::*; #(
  parameter int DEPTH = SIG_DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             en,
  input  logic [IDX_W-1:0] idx,
  output logic [SIG_W-1:0] sig
);

  logic [SIG_W-1:0] tbl [DEPTH];

  // entry = sigmoid of bin center over [-8, 8), Q0.16 truncated
  for (genvar g = 0; g < DEPTH; g++) begin : g_ent
    localparam longint X = -SIG_HALF_RANGE + ((2 * g + 1) * SIG_HALF_RANGE) / DEPTH;
    localparam longint unsigned T = (X < 0) ? -X : X;
    localparam longint unsigned E = exp_neg_q31(T);
    localparam longint unsigned S = (X >= 0) ? (ONE_Q31 << 16) / (ONE_Q31 + E)
                                             : (E << 16) / (ONE_Q31 + E);
    assign tbl[g] = S[SIG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sig <= tbl[idx];
    end
  end

endmodule

// ===== rtl/tiny_cnn_patch_inference_core.sv =====
`timescale 1ns / 1ps
// Load request: writes the weight at acceptance, no result.
// Evaluate request: 70 microcode steps on one shared multiply-accumulate;
// the result is registered by the final step, held while an earlier result stalls at the output.
// The next request is taken once the step pipeline drains, even while a result waits at the output.
// Reset clears the sequencer and handshake state; weights are undefined until loaded.

module tiny_cnn_patch_inference_core import tcnn_pkg::*; #(
  parameter int SIGMOID_TABLE_DEPTH = SIG_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    op,
  input  logic [WADDR_W-1:0]      weight_index,
  input  logic signed [W_W-1:0]   weight_value,
  input  logic [PIX_W-1:0]        p00,
  input  logic [PIX_W-1:0]        p01,
  input  logic [PIX_W-1:0]        p02,
  input  logic [PIX_W-1:0]        p10,
  input  logic [PIX_W-1:0]        p11,
  input  logic [PIX_W-1:0]        p12,
  input  logic [PIX_W-1:0]        p20,
  input  logic [PIX_W-1:0]        p21,
  input  logic [PIX_W-1:0]        p22,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] output_sum
);

  localparam int IDX_W = $clog2(SIGMOID_TABLE_DEPTH);
  localparam int DEP_W = $clog2(SIGMOID_TABLE_DEPTH + 1);
  localparam int IDX_IN_W = HLIM_SHIFT + 1;
  localparam int MUL_W = IDX_IN_W + DEP_W;
  localparam logic [MUL_W-1:0] DEPTH_K = MUL_W'(SIGMOID_TABLE_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SIGMOID_TABLE_DEPTH - 1);
  localparam logic signed [HID_W-1:0] H_OFF =
    {{(HID_W - HLIM_SHIFT - 1){1'b0}}, 1'b1, {HLIM_SHIFT{1'b0}}};

  // microcode program
  ucw_t ucode [UC_LEN];

  for (genvar gi = 0; gi < 2; gi++) begin : g_row
    for (genvar gj = 0; gj < 2; gj++) begin : g_col
      for (genvar gf = 0; gf < HID_COUNT; gf++) begin : g_flt
        for (genvar gk = 0; gk < 5; gk++) begin : g_stp
          localparam int POS = gi * 2 + gj;
          localparam int PC = POS * 15 + gf * 5 + gk;
          localparam int PIX = (gi + gk / 2) * 3 + gj + gk % 2;
          if (gk < 4) begin : g_px
            assign ucode[PC] = mk_word(ACT_MAC, A_PIX, D_SACC, J_NEXT, gk == 0, 1'b0,
                                       PIX_SEL_W'(PIX), WADDR_W'(gf * 4 + gk),
                                       HSEL_W'(gf), '0);
          end else begin : g_pw
            assign ucode[PC] = mk_word(ACT_MAC, A_SACC, D_HID, J_NEXT, POS == 0, 1'b0,
                                       '0, WADDR_W'(W_POS_BASE + POS),
                                       HSEL_W'(gf), '0);
          end
        end
      end
    end
  end

  assign ucode[UC_SIG] = mk_word(ACT_IDX, A_PIX, D_HID, J_NEXT, 1'b0, 1'b1,
                                 '0, '0, '0, '0);
  assign ucode[UC_SIG + 1] = mk_word(ACT_ROM, A_PIX, D_HID, J_NEXT, 1'b0, 1'b1,
                                     '0, '0, '0, '0);
  assign ucode[UC_SIG + 2] = mk_word(ACT_MAC, A_SIG, D_OUT, J_LOOP, 1'b0, 1'b1,
                                     '0, WADDR_W'(W_OUT_BASE), '0, PC_W'(UC_SIG));
  assign ucode[UC_FIN] = mk_word(ACT_FIN, A_PIX, D_OUT, J_END, 1'b0, 1'b0,
                                 '0, '0, '0, '0);

  // sequencer and fetch stage
  logic                in_acc;
  logic                run;
  logic                run_next;
  logic [PC_W-1:0]     pc;
  logic [PC_W-1:0]     pc_next;
  logic [HSEL_W-1:0]   lcnt;
  logic [HSEL_W-1:0]   lcnt_next;
  ucw_t                cw;
  ucw_t                fetch;

  logic [W_W-1:0]      wstore [WEIGHT_COUNT];
  logic [PIX_W-1:0]    px_q [PIX_COUNT];

  // execute stage
  logic                ex_v;
  logic                hold;
  logic                exec;
  ucw_t                cw_q;
  logic signed [A_W-1:0]    a_q;
  logic signed [W_W-1:0]    b_q;
  logic signed [A_W-1:0]    a_op;
  logic signed [PROD_W-1:0] prod;
  logic signed [HID_W-1:0]  base;
  logic signed [HID_W-1:0]  sum;
  logic signed [S_W-1:0]    s_acc;
  logic signed [HID_W-1:0]  hidden [HID_COUNT];
  logic signed [OACC_W-1:0] out_acc;
  logic signed [HID_W-1:0]  h_off;
  logic [MUL_W-1:0]         idx_mul;
  logic [IDX_W-1:0]         idx_new;
  logic [IDX_W-1:0]         idx_q;
  logic [SIG_W-1:0]         sig;
  logic                     fin;

  assign in_stall = run || ex_v;
  assign in_acc = in_valid && !in_stall;

  always_comb begin
    cw = ucode[pc];
    fetch = cw;
    if (cw.use_cnt) begin
      fetch.waddr = cw.waddr + {{(WADDR_W - HSEL_W){1'b0}}, lcnt};
      fetch.hsel = lcnt;
    end
  end

  always_comb begin
    pc_next = pc;
    lcnt_next = lcnt;
    run_next = run;
    if (in_acc && op == OP_EVAL) begin
      run_next = 1'b1;
      pc_next = '0;
      lcnt_next = '0;
    end else if (run) begin
      unique case (cw.jmp)
        J_NEXT: pc_next = pc + 1'b1;
        J_LOOP: begin
          if (lcnt == LOOP_LAST) begin
            lcnt_next = '0;
            pc_next = pc + 1'b1;
          end else begin
            lcnt_next = lcnt + 1'b1;
            pc_next = cw.target;
          end
        end
        J_END: run_next = 1'b0;
        default: run_next = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      pc <= '0;
      lcnt <= '0;
    end else begin
      run <= run_next;
      pc <= pc_next;
      lcnt <= lcnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && op == OP_LOAD && weight_index < WADDR_W'(WEIGHT_COUNT)) begin
      wstore[weight_index] <= weight_value;
    end
    if (in_acc && op == OP_EVAL) begin
      px_q[0] <= p00;
      px_q[1] <= p01;
      px_q[2] <= p02;
      px_q[3] <= p10;
      px_q[4] <= p11;
      px_q[5] <= p12;
      px_q[6] <= p20;
      px_q[7] <= p21;
      px_q[8] <= p22;
    end
    if (run) begin
      cw_q <= fetch;
      a_q <= {{(A_W - PIX_W){1'b0}}, px_q[cw.pix]};
      b_q <= wstore[fetch.waddr];
    end
  end

  // execute: shared MAC, sigmoid index, table read, result
  assign hold = ex_v && cw_q.act == ACT_FIN && out_valid && out_stall;
  assign exec = ex_v && !hold;
  assign fin = exec && cw_q.act == ACT_FIN;

  always_comb begin
    unique case (cw_q.asel)
      A_PIX:   a_op = a_q;
      A_SACC:  a_op = s_acc;
      A_SIG:   a_op = {{(A_W - SIG_W){1'b0}}, sig};
      default: a_op = a_q;
    endcase
  end

  assign prod = a_op * b_q;

  always_comb begin
    unique case (cw_q.dst)
      D_SACC:  base = {{(HID_W - S_W){s_acc[S_W-1]}}, s_acc};
      D_HID:   base = hidden[cw_q.hsel];
      D_OUT:   base = {{(HID_W - OACC_W){out_acc[OACC_W-1]}}, out_acc};
      default: base = '0;
    endcase
    if (cw_q.clr) begin
      base = '0;
    end
    sum = base + {{(HID_W - PROD_W){prod[PROD_W-1]}}, prod};
  end

  // bin index = floor((h + 8) * depth / 16), clamped to the table
  always_comb begin
    h_off = hidden[cw_q.hsel] + H_OFF;
    idx_mul = {{DEP_W{1'b0}}, h_off[IDX_IN_W-1:0]} * DEPTH_K;
    priority if (h_off[HID_W-1]) begin
      idx_new = '0;
    end else if (|h_off[HID_W-2:IDX_IN_W]) begin
      idx_new = IDX_LAST;
    end else begin
      idx_new = idx_mul[IDX_IN_W +: IDX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (exec && cw_q.act == ACT_MAC) begin
      if (cw_q.dst == D_SACC) begin
        s_acc <= sum[S_W-1:0];
      end
      if (cw_q.dst == D_HID) begin
        hidden[cw_q.hsel] <= sum;
      end
    end
    if (in_acc && op == OP_EVAL) begin
      out_acc <= '0;
    end else if (exec && cw_q.act == ACT_MAC && cw_q.dst == D_OUT) begin
      out_acc <= sum[OACC_W-1:0];
    end
    if (exec && cw_q.act == ACT_IDX) begin
      idx_q <= idx_new;
    end
    // floor to Q15.16; the sum cannot leave 32 bits
    if (fin) begin
      output_sum <= {{(OUT_W - OACC_W + FRAC_DROP){out_acc[OACC_W-1]}},
                     out_acc[OACC_W-1:FRAC_DROP]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_v <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!hold) begin
        ex_v <= run;
      end
      if (fin) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  tcnn_sig_rom #(
    .DEPTH (SIGMOID_TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_sig_rom (
    .clk (clk),
    .en  (exec && cw_q.act == ACT_ROM),
    .idx (idx_q),
    .sig (sig)
  );

`ifndef SYNTHESIS
  a_fin_after_fetch: assert property (@(posedge clk) disable iff (rst)
    ex_v && cw_q.act == ACT_FIN |-> !run)
    else $error("result step executed while sequencer still fetching");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ex_v && cw_q.act == ACT_FIN))
    else $error("result appeared without a final step");

  a_sacc_to_hidden: assert property (@(posedge clk) disable iff (rst)
    ex_v && cw_q.act == ACT_MAC && cw_q.asel == A_SACC |-> cw_q.dst == D_HID)
    else $error("filter sum routed to wrong accumulator");
`endif

endmodule

// ===== tb/tiny_cnn_patch_inference_core_tb.sv =====
`timescale 1ns / 1ps

module tiny_cnn_patch_inference_core_tb;
  import tcnn_pkg::*;

  localparam int SIG_DEPTH = SIG_DEPTH_DEF;
  localparam int ITEMS_PER_PHASE = 500;
  localparam int HOLD_CYCLES = 600;
  localparam int STUCK_LIMIT = 5000;
  localparam int DIR_N = 26;

  typedef struct packed {
    logic                    op;
    logic [WADDR_W-1:0]      idx;
    logic [W_W-1:0]          val;
    logic [PIX_W-1:0]        pa;
    logic [PIX_W-1:0]        pb;
    logic                    typed;
    logic signed [OUT_W-1:0] want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic op;
  logic [WADDR_W-1:0] weight_index;
  logic signed [W_W-1:0] weight_value;
  logic [PIX_W-1:0] p00, p01, p02, p10, p11, p12, p20, p21, p22;
  logic out_valid;
  logic out_stall;
  logic signed [OUT_W-1:0] output_sum;

  // predictor state
  logic signed [W_W-1:0] wt_model [WEIGHT_COUNT];
  longint unsigned sig_lut [SIG_DEPTH];
  logic signed [OUT_W-1:0] sum_q [$];
  logic signed [OUT_W-1:0] want_sum;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;
  int stuck_cycles = 0;
  int err_cnt = 0;
  int n_loads = 0;
  int n_evals = 0;
  int n_results = 0;

  tiny_cnn_patch_inference_core #(
    .SIGMOID_TABLE_DEPTH(SIG_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .weight_index(weight_index),
    .weight_value(weight_value),
    .p00(p00),
    .p01(p01),
    .p02(p02),
    .p10(p10),
    .p11(p11),
    .p12(p12),
    .p20(p20),
    .p21(p21),
    .p22(p22),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .output_sum(output_sum)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // e^-t for t in Q16, Q31 result: cubic series at t/256, squared eight times
  function automatic longint unsigned decay_q31(input longint unsigned t_q16);
    longint unsigned u;
    longint unsigned u2;
    longint unsigned u3;
    longint unsigned acc;
    u = t_q16 << 7;
    u2 = (u * u) >> 31;
    u3 = (u2 * u) >> 31;
    acc = ONE_Q31 - u + (u2 >> 1) - u3 / 6;
    repeat (8) acc = (acc * acc) >> 31;
    return acc;
  endfunction

  function automatic logic signed [OUT_W-1:0] patch_net_eval(input logic [9*PIX_W-1:0] pix);
    longint hid [3];
    longint s;
    longint pw;
    longint acc;
    longint res;
    longint lim;
    longint bin;
    int f, i, j, q, r;
    lim = longint'(1) << 42;
    acc = 0;
    for (f = 0; f < 3; f++) hid[f] = 0;
    for (i = 0; i < 2; i++) begin
      for (j = 0; j < 2; j++) begin
        pw = longint'(wt_model[W_POS_BASE + i * 2 + j]);
        for (f = 0; f < 3; f++) begin
          s = 0;
          for (q = 0; q < 2; q++) begin
            for (r = 0; r < 2; r++) begin
              s += longint'(pix[((i + q) * 3 + j + r) * PIX_W +: PIX_W]) *
                   longint'(wt_model[f * 4 + q * 2 + r]);
            end
          end
          hid[f] += s * pw;
        end
      end
    end
    for (f = 0; f < 3; f++) begin
      if (hid[f] < -lim) begin
        bin = 0;
      end else if (hid[f] >= lim) begin
        bin = SIG_DEPTH - 1;
      end else begin
        bin = ((hid[f] + lim) * SIG_DEPTH) >>> 43;
      end
      if (bin > SIG_DEPTH - 1) bin = SIG_DEPTH - 1;
      acc += longint'(sig_lut[bin]) * longint'(wt_model[W_OUT_BASE + f]);
    end
    res = acc >>> 12;
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return res[OUT_W-1:0];
  endfunction

  task automatic send_req(input logic req_op, input logic [WADDR_W-1:0] idx,
                          input logic [W_W-1:0] val, input logic [9*PIX_W-1:0] pix,
                          input logic typed, input logic signed [OUT_W-1:0] want);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= req_op;
    weight_index <= idx;
    weight_value <= val;
    p00 <= pix[0*PIX_W +: PIX_W];
    p01 <= pix[1*PIX_W +: PIX_W];
    p02 <= pix[2*PIX_W +: PIX_W];
    p10 <= pix[3*PIX_W +: PIX_W];
    p11 <= pix[4*PIX_W +: PIX_W];
    p12 <= pix[5*PIX_W +: PIX_W];
    p20 <= pix[6*PIX_W +: PIX_W];
    p21 <= pix[7*PIX_W +: PIX_W];
    p22 <= pix[8*PIX_W +: PIX_W];
    do @(posedge clk); while (in_stall);
    if (req_op == OP_LOAD) begin
      n_loads++;
      if (idx < WEIGHT_COUNT) wt_model[idx] = val;
    end else begin
      n_evals++;
      sum_q.push_back(typed ? want : patch_net_eval(pix));
    end
    @(negedge clk);
  endtask

  // output side stall, with one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (sum_q.size() == 0) begin
        err_cnt++;
        $display("%0t: output_sum %0d with no evaluate outstanding", $time, output_sum);
      end else begin
        want_sum = sum_q.pop_front();
        if (output_sum !== want_sum) begin
          err_cnt++;
          $display("%0t: output_sum expected %0d got %0d", $time, want_sum, output_sum);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no request or result for %0d cycles", $time, STUCK_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_tab [DIR_N];
    logic [9*PIX_W-1:0] pix;
    logic [W_W-1:0] val;
    logic [WADDR_W-1:0] idx;
    logic req_op;
    longint x;
    longint unsigned t;
    longint unsigned e;
    int i, k, ph;

    // sigmoid bins over [-8, 8), value at bin center, Q0.16
    for (i = 0; i < SIG_DEPTH; i++) begin
      x = -64'sd524288 + ((2 * i + 1) * 64'sd524288) / SIG_DEPTH;
      t = (x < 0) ? -x : x;
      e = decay_q31(t);
      if (x >= 0) sig_lut[i] = (64'd1 << 47) / (ONE_Q31 + e);
      else sig_lut[i] = (e << 16) / (ONE_Q31 + e);
    end

    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_LOAD;
    weight_index = '0;
    weight_value = '0;
    {p00, p01, p02, p10, p11, p12, p20, p21, p22} = '0;

    // slots past 19 are ignored; filters at both extremes; zero patch gives 0
    dir_tab[0]  = '{OP_LOAD, 5'd31, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, 32'sd0};
    dir_tab[1]  = '{OP_LOAD, 5'd20, 16'h8000, 16'h0000, 16'h0000, 1'b0, 32'sd0};
    dir_tab[2]  = '{OP_LOAD, 5'd0,  16'h7FFF, 16'h0000, 16'h0000, 1'b0, 32'sd0};
    dir_tab[3]  = '{OP_LOAD, 5'd1,  16'h7FFF, 16'h0000, 16'h0000, 1'b0, 32'sd0};
    dir_tab[4]  = '{OP_LOAD, 5'd2,  16'h7FFF, 16'h0000, 16'h0000, 1'b0, 32'sd0};
    dir_tab[5]  = '{OP_LOAD, 5'd3,  16'h7FFF, 16'h0000, 16'h0000, 1'b0, 32'sd0};
    dir_tab[6]  = '{OP_LOAD, 5'd4,  16'h8000, 16'h0000, 16'h0000, 1'b0, 32'sd0};
    dir_tab[7]  = '{OP_LOAD, 5'd5,  16'h8000, 16'h0000, 16'h0000, 1'b0, 32'sd0};
    dir_tab[8]  = '{OP_LOAD, 5'd6,  16'h8000, 16'h0000, 16'h0000, 1'b0, 32'sd0};
    dir_tab[9]  = '{OP_LOAD, 5'd7,  16'h8000, 16'h0000, 16'h0000, 1'b0, 32'sd0};
    dir_tab[10] = '{OP_LOAD, 5'd8,  16'h0100, 16'h0000, 16'h0000, 1'b0, 32'sd0};
    dir_tab[11] = '{OP_LOAD, 5'd9,  16'h0100, 16'h0000, 16'h0000, 1'b0, 32'sd0};
    dir_tab[12] = '{OP_LOAD, 5'd10, 16'h0100, 16'h0000, 16'h0000, 1'b0, 32'sd0};
    dir_tab[13] = '{OP_LOAD, 5'd11, 16'h0100, 16'h0000, 16'h0000, 1'b0, 32'sd0};
    dir_tab[14] = '{OP_LOAD, 5'd12, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, 32'sd0};
    dir_tab[15] = '{OP_LOAD, 5'd13, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, 32'sd0};
    dir_tab[16] = '{OP_LOAD, 5'd14, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, 32'sd0};
    dir_tab[17] = '{OP_LOAD, 5'd15, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, 32'sd0};
    dir_tab[18] = '{OP_LOAD, 5'd16, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, 32'sd0};
    dir_tab[19] = '{OP_LOAD, 5'd17, 16'h8000, 16'h0000, 16'h0000, 1'b0, 32'sd0};
    dir_tab[20] = '{OP_LOAD, 5'd18, 16'h0001, 16'h0000, 16'h0000, 1'b0, 32'sd0};
    dir_tab[21] = '{OP_LOAD, 5'd19, 16'h8000, 16'h0000, 16'h0000, 1'b0, 32'sd0};
    dir_tab[22] = '{OP_EVAL, 5'd0,  16'h0000, 16'h0000, 16'h0000, 1'b1, 32'sd0};
    dir_tab[23] = '{OP_EVAL, 5'd0,  16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, 32'sd0};
    dir_tab[24] = '{OP_EVAL, 5'd0,  16'h0000, 16'h8000, 16'h0000, 1'b0, 32'sd0};
    dir_tab[25] = '{OP_EVAL, 5'd0,  16'h0000, 16'h0000, 16'hFFFF, 1'b0, 32'sd0};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    tx_idle_pct = 26;
    rx_idle_pct = 49;
    for (i = 0; i < DIR_N; i++) begin
      for (k = 0; k < 9; k++) begin
        pix[k*PIX_W +: PIX_W] = (k % 2 == 0) ? dir_tab[i].pa : dir_tab[i].pb;
      end
      send_req(dir_tab[i].op, dir_tab[i].idx, dir_tab[i].val, pix,
               dir_tab[i].typed, dir_tab[i].want);
    end

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 26;
          rx_idle_pct = 49;
        end
        1: begin
          tx_idle_pct = 49;
          rx_idle_pct = 26;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (ph == 0 && i == 200) hold_req = 1'b1;
        if (ph == 1 && i == 250) begin
          // drain everything before going on
          in_valid <= 1'b0;
          wait (sum_q.size() == 0);
          @(negedge clk);
        end
        req_op = ($urandom_range(0, 99) < 40) ? OP_LOAD : OP_EVAL;
        idx = WADDR_W'(($urandom_range(0, 9) == 0) ? $urandom_range(20, 31)
                                                   : $urandom_range(0, 19));
        // mostly small weights so hidden values land inside the sigmoid range
        val = W_W'(($urandom_range(0, 3) == 0) ? $urandom
                                               : $urandom_range(0, 3000) - 1500);
        for (k = 0; k < 9; k++) begin
          case ($urandom_range(0, 9))
            0: pix[k*PIX_W +: PIX_W] = 16'h0000;
            1: pix[k*PIX_W +: PIX_W] = 16'h8000;
            2: pix[k*PIX_W +: PIX_W] = PIX_W'($urandom);
            default: pix[k*PIX_W +: PIX_W] = PIX_W'($urandom_range(0, 32768));
          endcase
        end
        send_req(req_op, idx, val, pix, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    wait (sum_q.size() == 0);
    repeat (100) @(posedge clk);

    $display("checked %0d results from %0d evaluations and %0d weight loads",
             n_results, n_evals, n_loads);
    $display("saturated and mid-range sigmoid bins, ignored slots, over-range pixels, hold-off");
    if (err_cnt == 0 && sum_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
